>>> hdl/wamt_pkg.sv
`timescale 1ns / 1ps
// Package for the weekly alarm match table: item types, table entry type,
// operation and result codes and the default table size. Depends on nothing.

package wamt_pkg;

    localparam int DEF_CAPACITY = 16;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Kind codes of a result item.
    localparam logic [1:0] KIND_FIRED  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam int         MIN_PER_HOUR  = 60;
    localparam logic [7:0] YEAR_SYNC_MIN = 8'd70;
    localparam logic [8:0] MAX_ID        = 9'd255;
    localparam logic [10:0] NO_MINUTE    = 11'd2047;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
        logic [7:0]  years_since_1900;
        logic [10:0] start_minute;
        logic [10:0] end_minute;
        logic [2:0]  entry_day;
        logic [7:0]  remove_id;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] entry_id;
        logic       ok;
        logic       last;
    } t_out;

    // One stored alarm entry, 33 bits.
    typedef struct packed {
        logic [7:0]  id;
        logic [10:0] start;
        logic [10:0] stop;
        logic [2:0]  day;
    } t_entry;

endpackage

>>> hdl/wamt_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.

module wamt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/weekly_alarm_match_table.sv
`timescale 1ns / 1ps
// Top level of the weekly alarm match table: control sequencer around one
// entry memory. Depends on wamt_pkg and wamt_ram.
//
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  -------------------------
// command   in         start high, busy low       i_item   (wamt_pkg::t_in)
// result    out        o_result_strobe, 1 cycle   o_result (wamt_pkg::t_out)
// config    in         i_cfg_we                   i_cfg_wdata (enabled)
//
// An add, a remove or a tick that is not ignored raises busy until it is
// done; the table scan reads the entry memory one entry per cycle, and an
// add or a remove on an empty table skips the scan. The final result item
// shows in the same cycle as busy falls.
// An ignored tick and operation code 3 are taken without raising busy.
// After the synchronous reset the table is empty, no minute has been seen
// and the block is enabled. The receiver cannot stall: every result item is
// shown for exactly one cycle and is taken at the edge that ends it.

module weekly_alarm_match_table #(
    parameter int CAPACITY = wamt_pkg::DEF_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  wamt_pkg::t_in  i_item,
    output logic           o_result_strobe,
    output wamt_pkg::t_out o_result,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);

    import wamt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // Day of week with Monday as 0; the unused code 7 counts as Sunday.
    function automatic logic [2:0] monday_day(input logic [2:0] wd);
        logic [2:0] d;
        if (wd == 3'd0 || wd == 3'd7) begin
            d = 3'd6;
        end else begin
            d = wd - 3'd1;
        end
        return d;
    endfunction

    // Control state.
    t_state        r_state, n_state;
    logic          r_enabled, n_enabled;
    logic [CW-1:0] r_count, n_count;
    logic [10:0]   r_last_min, n_last_min;
    logic          r_dv, n_dv;
    logic          r_dv_final, n_dv_final;
    logic          r_held_v, n_held_v;
    logic          r_out_v, n_out_v;

    // Payload and scan working registers.
    t_in           r_item, n_item;
    logic [10:0]   r_now, n_now;
    logic [2:0]    r_day, n_day;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_kept, n_kept;
    logic          r_found, n_found;
    logic [8:0]    r_new_id, n_new_id;
    logic [7:0]    r_held_id, n_held_id;
    t_out          r_out, n_out;

    // Entry memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    logic          accept;
    logic [10:0]   acc_now;
    logic          tick_live;
    logic          add_fail;

    wamt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign accept  = start && (r_state == S_IDLE);
    // Minute of day from the tick fields, used as given even when out of range.
    assign acc_now = 11'(i_item.hour) * 11'(MIN_PER_HOUR) + 11'(i_item.minute);
    assign tick_live = r_enabled && (r_count != '0)
                    && (i_item.years_since_1900 >= YEAR_SYNC_MIN)
                    && (acc_now != r_last_min);
    assign add_fail = !r_enabled || (r_count >= CAP_C) || (r_new_id > MAX_ID);

    always_comb begin
        n_state    = r_state;
        n_enabled  = i_cfg_we ? i_cfg_wdata : r_enabled;
        n_count    = r_count;
        n_last_min = r_last_min;
        n_dv       = 1'b0;
        n_dv_final = 1'b0;
        n_held_v   = r_held_v;
        n_out_v    = 1'b0;
        n_item     = r_item;
        n_now      = r_now;
        n_day      = r_day;
        n_rd_idx   = r_rd_idx;
        n_kept     = r_kept;
        n_found    = r_found;
        n_new_id   = r_new_id;
        n_held_id  = r_held_id;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_kept[AW-1:0];
        ram_wdata  = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item   = i_item;
                    n_now    = acc_now;
                    n_day    = monday_day(i_item.weekday);
                    n_rd_idx = '0;
                    n_kept   = '0;
                    n_found  = 1'b0;
                    n_new_id = '0;
                    n_held_v = 1'b0;
                    priority if (i_item.operation == OP_TICK) begin
                        // An ignored tick leaves the table and the seen minute alone.
                        if (tick_live) begin
                            n_last_min = acc_now;
                            n_state    = S_SCAN;
                        end
                    end else if (i_item.operation == OP_ADD
                              || i_item.operation == OP_REMOVE) begin
                        n_state = (r_count == '0) ? S_FINISH : S_SCAN;
                    end else begin
                        // The unused operation code is taken and dropped.
                    end
                end
            end

            S_SCAN: begin
                // Issue one read per cycle; the data returns in the next cycle, together with r_dv.
                if (r_rd_idx < r_count) begin
                    n_dv       = 1'b1;
                    n_dv_final = (r_rd_idx + ONE_C == r_count);
                    n_rd_idx   = r_rd_idx + ONE_C;
                end
                if (r_dv) begin
                    unique case (r_item.operation)
                        OP_TICK: begin
                            // A match is held back one step so that the final
                            // match can carry the last flag.
                            if (ram_rdata.day == r_day && ram_rdata.start == r_now) begin
                                if (r_held_v) begin
                                    n_out_v = 1'b1;
                                    n_out   = '{kind: KIND_FIRED, entry_id: r_held_id,
                                                ok: 1'b1, last: 1'b0};
                                end
                                n_held_v  = 1'b1;
                                n_held_id = ram_rdata.id;
                            end
                        end
                        OP_ADD: begin
                            if (9'(ram_rdata.id) >= r_new_id) begin
                                n_new_id = 9'(ram_rdata.id) + 9'd1;
                            end
                        end
                        OP_REMOVE: begin
                            // Kept entries move down; the write address never
                            // passes the read address, so no entry is overwritten
                            // before it is read.
                            if (ram_rdata.id == r_item.remove_id) begin
                                n_found = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                n_kept = r_kept + ONE_C;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (r_dv_final) begin
                        n_state = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                n_state = S_IDLE;
                unique case (r_item.operation)
                    OP_TICK: begin
                        if (r_held_v) begin
                            n_out_v = 1'b1;
                            n_out   = '{kind: KIND_FIRED, entry_id: r_held_id,
                                        ok: 1'b1, last: 1'b1};
                        end
                        n_held_v = 1'b0;
                    end
                    OP_ADD: begin
                        n_out_v = 1'b1;
                        if (add_fail) begin
                            n_out = '{kind: KIND_ADD, entry_id: 8'd0, ok: 1'b0, last: 1'b1};
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AW-1:0];
                            ram_wdata = '{id: r_new_id[7:0], start: r_item.start_minute,
                                          stop: r_item.end_minute, day: r_item.entry_day};
                            n_count   = r_count + ONE_C;
                            n_out     = '{kind: KIND_ADD, entry_id: r_new_id[7:0],
                                          ok: 1'b1, last: 1'b1};
                        end
                    end
                    OP_REMOVE: begin
                        n_out_v = 1'b1;
                        n_count = r_kept;
                        n_out   = '{kind: KIND_REMOVE, entry_id: r_item.remove_id,
                                    ok: r_found, last: 1'b1};
                    end
                    default: begin
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_enabled  <= 1'b1;
            r_count    <= '0;
            r_last_min <= NO_MINUTE;
            r_dv       <= 1'b0;
            r_dv_final <= 1'b0;
            r_held_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_enabled  <= n_enabled;
            r_count    <= n_count;
            r_last_min <= n_last_min;
            r_dv       <= n_dv;
            r_dv_final <= n_dv_final;
            r_held_v   <= n_held_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_now     <= n_now;
        r_day     <= n_day;
        r_rd_idx  <= n_rd_idx;
        r_kept    <= n_kept;
        r_found   <= n_found;
        r_new_id  <= n_new_id;
        r_held_id <= n_held_id;
        r_out     <= n_out;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_out_v;
    assign o_result        = r_out;

endmodule

>>> bench/weekly_alarm_match_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for weekly_alarm_match_table: random and directed items,
// with a scoreboard that mirrors the alarm table. Depends on wamt_pkg and the RTL.

module weekly_alarm_match_table_test;

    import wamt_pkg::*;

    localparam int         CAPACITY      = DEF_CAPACITY;
    localparam int         REPORT_LIMIT  = 10;
    // The slowest item is a random gap plus a full table scan.
    // Fewer than a thousand items are sent, so this leaves a wide margin.
    localparam int         CYCLE_LIMIT   = 300000;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_result_strobe;
    t_out o_result;
    logic i_cfg_we;
    logic i_cfg_wdata;

    int         cycles = 0;
    bit         steady;              // when set, the sender runs without gaps
    logic [10:0] hot_minutes [4];    // shared start minutes, so entries fire together

    // The scoreboard keeps its own copy of the table, the enable bit and the
    // last minute seen. Every accepted item is played against that copy and
    // the result items it must cause are queued in order.
    class alarm_table_scoreboard;
        t_entry      rows[$];
        logic [10:0] last_minute;
        logic        enabled;
        t_out        due_results[$];
        int          mismatches;

        function new();
            last_minute = NO_MINUTE;
            enabled     = 1'b1;
            mismatches  = 0;
        endfunction

        // One past the largest id in the table, or zero when it is empty.
        function int next_id();
            int id;
            id = 0;
            foreach (rows[k]) if (rows[k].id >= id) id = rows[k].id + 1;
            return id;
        endfunction

        function void owe(logic [1:0] kind, logic [7:0] id, logic ok, logic last);
            t_out r;
            r.kind     = kind;
            r.entry_id = id;
            r.ok       = ok;
            r.last     = last;
            due_results.insert(due_results.size(), r);
        endfunction

        function void take_command(input t_in cmd);
            logic [10:0] now;
            logic [2:0]  mon_day;
            logic [7:0]  hits[$];
            t_entry      row;
            int          id;
            bit          found;
            case (cmd.operation)
                OP_TICK: begin
                    if (!enabled || rows.size() == 0 || cmd.years_since_1900 < YEAR_SYNC_MIN)
                        return;
                    now = 11'(cmd.hour * MIN_PER_HOUR + cmd.minute);
                    if (now == last_minute)
                        return;
                    last_minute = now;
                    // Sunday-based weekday to Monday-based day; 7 lands on Sunday too.
                    mon_day = 3'((cmd.weekday + 6) % 7);
                    foreach (rows[k])
                        if (rows[k].day == mon_day && rows[k].start == now)
                            hits.insert(hits.size(), rows[k].id);
                    foreach (hits[k]) owe(KIND_FIRED, hits[k], 1'b1, k == hits.size() - 1);
                end
                OP_ADD: begin
                    id = next_id();
                    if (!enabled || rows.size() >= CAPACITY || id > MAX_ID) begin
                        owe(KIND_ADD, 8'd0, 1'b0, 1'b1);
                    end else begin
                        row.id    = 8'(id);
                        row.start = cmd.start_minute;
                        row.stop  = cmd.end_minute;
                        row.day   = cmd.entry_day;
                        rows.insert(rows.size(), row);
                        owe(KIND_ADD, 8'(id), 1'b1, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    found = 1'b0;
                    // Deleting from the back keeps the order of the survivors.
                    for (int k = rows.size() - 1; k >= 0; k--) begin
                        if (rows[k].id == cmd.remove_id) begin
                            rows.delete(k);
                            found = 1'b1;
                        end
                    end
                    owe(KIND_REMOVE, cmd.remove_id, found, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_outcome(input t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result kind %0d id %0d ok %0b last %0b",
                             $time, got.kind, got.entry_id, got.ok, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.entry_id !== want.entry_id ||
                got.ok !== want.ok || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: expected kind %0d id %0d ok %0b last %0b,",
                             $time, want.kind, want.entry_id, want.ok, want.last,
                             " got kind %0d id %0d ok %0b last %0b",
                             got.kind, got.entry_id, got.ok, got.last);
            end
        endfunction
    endclass

    alarm_table_scoreboard board;

    weekly_alarm_match_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            board.check_outcome(o_result);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Item builders. Fields that the operation does not use carry random noise.
    function automatic t_in noise_item(input logic [1:0] op);
        logic [63:0] raw;
        t_in         item;
        raw = {$urandom(), $urandom()};
        item = raw[$bits(t_in)-1:0];
        item.operation = op;
        return item;
    endfunction

    function automatic t_in tick_item(input logic [4:0] hh, input logic [5:0] mm,
                                      input logic [2:0] wd, input logic [7:0] yy);
        t_in item;
        item = noise_item(OP_TICK);
        item.hour             = hh;
        item.minute           = mm;
        item.weekday          = wd;
        item.years_since_1900 = yy;
        return item;
    endfunction

    function automatic t_in add_item(input logic [10:0] st, input logic [10:0] sp,
                                     input logic [2:0] dy);
        t_in item;
        item = noise_item(OP_ADD);
        item.start_minute = st;
        item.end_minute   = sp;
        item.entry_day    = dy;
        return item;
    endfunction

    function automatic t_in remove_item(input logic [7:0] id);
        t_in item;
        item = noise_item(OP_REMOVE);
        item.remove_id = id;
        return item;
    endfunction

    // A tick aimed at one stored entry. Start minutes past 1859 are reached with
    // the out-of-range hour 31; beyond 1923 no tick can hit them.
    function automatic t_in tick_on(input t_entry row);
        logic [4:0] hh;
        logic [5:0] mm;
        logic [2:0] wd;
        logic [7:0] yy;
        if (row.start >= 11'd1860) begin
            hh = 5'd31;
            mm = 6'(row.start - 11'd1860);
        end else begin
            hh = 5'(row.start / MIN_PER_HOUR);
            mm = 6'(row.start % MIN_PER_HOUR);
        end
        wd = 3'((row.day + 1) % 7);
        if (row.day == 3'd6 && $urandom_range(0, 1) == 1)
            wd = 3'd7;
        yy = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 69))
                                         : 8'($urandom_range(70, 255));
        return tick_item(hh, mm, wd, yy);
    endfunction

    // Most adds share a few start minutes and days so that ticks fire several
    // entries at once; the rest use any value the field widths allow.
    function automatic t_in pool_add();
        if ($urandom_range(0, 4) == 0)
            return add_item(11'($urandom), 11'($urandom), 3'($urandom));
        return add_item(hot_minutes[$urandom_range(0, 3)], 11'($urandom_range(0, 1439)),
                        3'($urandom_range(0, 2)));
    endfunction

    function automatic t_in pick_item();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        n = board.rows.size();
        if (roll < 35 && n != 0)
            return tick_on(board.rows[$urandom_range(0, n - 1)]);
        if (roll < 45)
            return tick_item(5'($urandom), 6'($urandom), 3'($urandom), 8'($urandom));
        if (roll < 75)
            return pool_add();
        if (roll < 93 && n != 0)
            return remove_item(board.rows[$urandom_range(0, n - 1)].id);
        if (roll < 97)
            return remove_item(8'($urandom));
        return noise_item(OP_UNUSED);
    endfunction

    // Present one item from a falling edge and hold it until the block takes it.
    // Start stays high when the next item follows without a gap.
    task automatic issue(input t_in cmd);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item = cmd;
        start  = 1'b1;
        do @(posedge i_clk); while (busy);
        board.take_command(cmd);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every owed result. A tick that matches nothing
    // still scans the table, so a full scan's worth of cycles follows.
    task automatic settle();
        start = 1'b0;
        while (board.due_results.size() != 0) @(negedge i_clk);
        repeat (CAPACITY + 8) @(negedge i_clk);
    endtask

    task automatic write_enabled(input logic value);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        board.enabled = value;
    endtask

    initial begin
        logic [10:0] fill_start;
        board       = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        steady      = 1'b0;
        foreach (hot_minutes[k]) hot_minutes[k] = 11'($urandom_range(0, 1439));
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_enabled(1'b1);

        // Directed part: field extremes, each operation and the corner cases.
        issue(tick_item(10, 0, 3, 120));        // empty table, tick ignored
        issue(remove_item(8'd5));               // nothing to remove
        issue(add_item(0, 1439, 0));            // id 0, Monday midnight
        issue(add_item(1439, 0, 6));            // id 1, Sunday 23:59
        issue(add_item(2047, 2047, 7));         // id 2, out-of-range fields kept as given
        issue(add_item(1923, 100, 3));          // id 3, only reachable with hour 31 minute 63
        issue(add_item(0, 5, 0));               // id 4, shares a slot with id 0
        issue(tick_item(0, 0, 1, 70));          // first synced year, fires 0 and 4
        issue(tick_item(0, 0, 1, 70));          // same minute again, ignored
        issue(tick_item(23, 59, 0, 255));       // fires id 1
        issue(tick_item(31, 63, 4, 200));       // minute of day 1923, fires id 3
        issue(tick_item(23, 59, 7, 90));        // weekday 7 counts as Sunday
        issue(tick_item(0, 0, 1, 69));          // clock not synced, ignored
        issue(tick_item(12, 34, 2, 100));       // no entry matches
        issue(noise_item(OP_UNUSED));           // unused operation code
        issue(remove_item(8'd4));               // found, table compacts
        issue(remove_item(8'd4));               // already gone
        issue(remove_item(8'd255));
        write_enabled(1'b0);
        issue(add_item(30, 40, 2));             // refused while disabled
        issue(tick_item(0, 0, 1, 100));         // ignored while disabled
        issue(remove_item(8'd2));               // removes still work
        write_enabled(1'b1);
        issue(tick_item(0, 0, 1, 100));         // fires id 0 again
        issue(add_item(0, 0, 0));               // takes id 4

        // Random part in four stretches, the third one with the block disabled.
        // Now and then the sender drains the block before going on.
        for (int phase = 0; phase < 4; phase++) begin
            write_enabled(phase == 2 ? 1'b0 : 1'b1);
            for (int n = 0; n < (phase == 2 ? 20 : 60); n++) begin
                if (n % 16 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 24) == 0)
                    settle();
                issue(pick_item());
            end
        end

        // Fill the table with entries that all share one slot, so a single tick
        // fires every one of them, then try one add too many.
        write_enabled(1'b1);
        steady = 1'b0;
        while (board.rows.size() != 0)
            issue(remove_item(board.rows[0].id));
        fill_start = (board.last_minute == 11'd700) ? 11'd701 : 11'd700;
        while (board.rows.size() < CAPACITY && board.next_id() <= MAX_ID)
            issue(add_item(fill_start, 11'($urandom), 3'd4));
        issue(tick_on(board.rows[0]));
        issue(tick_item(5'(fill_start / MIN_PER_HOUR), 6'(fill_start % MIN_PER_HOUR),
                        3'd5, 8'd124));
        issue(pool_add());                      // refused, the table is full

        settle();
        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/wamt_pkg.sv
hdl/wamt_ram.sv
hdl/weekly_alarm_match_table.sv
bench/weekly_alarm_match_table_test.sv
